### rtl/checkpointed_stack_top_macros.svh
// Assertion macros used by the stack top module.
`ifndef CHECKPOINTED_STACK_TOP_MACROS_SVH
`define CHECKPOINTED_STACK_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CKS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CKS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cks_pkg.sv
package cks_pkg;

  // Operation codes carried in the op field.
  localparam logic [2:0] OP_PUSH     = 3'd0;
  localparam logic [2:0] OP_POP      = 3'd1;
  localparam logic [2:0] OP_READ     = 3'd2;
  localparam logic [2:0] OP_COMMIT   = 3'd3;
  localparam logic [2:0] OP_ROLLBACK = 3'd4;
  localparam logic [2:0] OP_CLEAR    = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef logic signed [31:0] word_t;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic push;
    logic commit;
    logic rollback;
    logic rotate;
  } cell_ctrl_t;

endpackage

### rtl/cks_cmd_if.sv
interface cks_cmd_if;
  import cks_pkg::*;

  logic       valid;
  logic       ready;
  logic [2:0] op;
  word_t      push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink (input valid, input op, input push_value, output ready);
endinterface

### rtl/cks_rsp_if.sv
interface cks_rsp_if;
  import cks_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       has_data;
  word_t      element;
  logic       last;

  modport source (output valid, output status, output has_data, output element,
                  output last, input ready);
  modport sink (input valid, input status, input has_data, input element,
                input last, output ready);
endinterface

### rtl/checkpointed_stack_top.sv
// LIFO stack of signed 32-bit values with nested whole-stack checkpoints,
// built as a row of STACK_DEPTH cells, each holding one stack entry and its
// own column of CHECKPOINT_DEPTH saved copies. Push, pop, commit, rollback
// and clear each give one result, so these operations sustain one item per
// cycle while results are taken. A read of n entries holds the command side
// from the cycle in which it is accepted until its n results have been
// given, one per cycle while results are taken, as the occupied cells
// rotate one place per result past the bottom cell; a read of an empty stack
// gives a single result. A result that waits for rsp.ready holds off further
// results and operations until it is taken. No new operation is accepted
// until the last result of a read has been loaded into the output register.
// Stack and checkpoint contents are not cleared at reset and need no
// clearing pass: only entries written since reset are ever read out.
module checkpointed_stack_top #(
  parameter int STACK_DEPTH      = 16,
  parameter int CHECKPOINT_DEPTH = 4
) (
  input logic        clk,
  input logic        rst,
  cks_cmd_if.sink    cmd,
  cks_rsp_if.source  rsp
);
  import cks_pkg::*;

  `include "checkpointed_stack_top_macros.svh"

  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int LVW = $clog2(CHECKPOINT_DEPTH + 1);
  localparam int IW  = (CHECKPOINT_DEPTH > 1) ? $clog2(CHECKPOINT_DEPTH) : 1;

  localparam logic [CW-1:0]  FULL_COUNT = CW'(STACK_DEPTH);
  localparam logic [LVW-1:0] FULL_LEVEL = LVW'(CHECKPOINT_DEPTH);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t         state, state_next;
  logic [CW-1:0]  count, count_next;
  logic [LVW-1:0] level, level_next;
  logic [CW-1:0]  rd_idx, rd_idx_next;
  logic [LVW-1:0] level_dec;
  logic [IW-1:0]  ckpt_idx;
  logic [CW-1:0]  counts [CHECKPOINT_DEPTH];
  logic           save_count;
  logic           out_free;
  logic           accept;
  cell_ctrl_t     ctrl;
  logic           emit;
  logic [1:0]     emit_status;
  logic           emit_has;
  word_t          emit_elem;
  logic           emit_last;
  word_t          cell_val [STACK_DEPTH];

  // Handshake on the command side.
  assign out_free  = !rsp.valid || rsp.ready;
  assign cmd.ready = (state == S_IDLE) && out_free;
  assign accept    = cmd.valid && cmd.ready;

  // Checkpoint slot: the new level on commit, the newest saved one on rollback.
  assign level_dec = level - LVW'(1);
  assign ckpt_idx  = (cmd.op == OP_ROLLBACK) ? level_dec[IW-1:0] : level[IW-1:0];

  // Operation decode and read sequencing.
  always_comb begin
    state_next  = state;
    count_next  = count;
    level_next  = level;
    rd_idx_next = rd_idx;
    ctrl        = '0;
    save_count  = 1'b0;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_has    = 1'b0;
    emit_elem   = '0;
    emit_last   = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd.op)
            OP_PUSH: begin
              emit = 1'b1;
              if (count == FULL_COUNT) begin
                emit_status = ST_FULL;
              end else begin
                ctrl.push  = 1'b1;
                count_next = count + CW'(1);
              end
            end
            OP_POP: begin
              emit = 1'b1;
              if (count == '0) begin
                emit_status = ST_EMPTY;
              end else begin
                count_next = count - CW'(1);
              end
            end
            OP_READ: begin
              if (count == '0) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end else begin
                rd_idx_next = '0;
                state_next  = S_READ;
              end
            end
            OP_COMMIT: begin
              emit = 1'b1;
              if (level == FULL_LEVEL) begin
                emit_status = ST_FULL;
              end else begin
                ctrl.commit = 1'b1;
                save_count  = 1'b1;
                level_next  = level + LVW'(1);
              end
            end
            OP_ROLLBACK: begin
              emit = 1'b1;
              if (level == '0) begin
                emit_status = ST_EMPTY;
              end else begin
                ctrl.rollback = 1'b1;
                level_next    = level_dec;
                count_next    = counts[level_dec[IW-1:0]];
              end
            end
            OP_CLEAR: begin
              emit       = 1'b1;
              count_next = '0;
              level_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_has    = 1'b1;
          emit_elem   = cell_val[0];
          emit_last   = (rd_idx + CW'(1)) == count;
          ctrl.rotate = 1'b1;
          rd_idx_next = rd_idx + CW'(1);
          if (emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, counters and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      level     <= '0;
      rd_idx    <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      level  <= level_next;
      rd_idx <= rd_idx_next;
      if (emit) begin
        rsp.valid    <= 1'b1;
        rsp.status   <= emit_status;
        rsp.has_data <= emit_has;
        rsp.element  <= emit_elem;
        rsp.last     <= emit_last;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Saved stack heights, one per checkpoint level.
  always_ff @(posedge clk) begin
    if (save_count) begin
      counts[level[IW-1:0]] <= count;
    end
  end

  // The row of cells; each hands its entry down to the cell below.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    cks_cell #(
      .STACK_DEPTH      (STACK_DEPTH),
      .CHECKPOINT_DEPTH (CHECKPOINT_DEPTH),
      .INDEX            (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count),
      .ckpt_idx    (ckpt_idx),
      .push_value  (cmd.push_value),
      .from_next   (cell_val[(i + 1) % STACK_DEPTH]),
      .from_bottom (cell_val[0]),
      .value       (cell_val[i])
    );
  end

  `CKS_ASSERT_SAME(a_read_blocks_cmd, clk, rst, state == S_READ, !cmd.ready,
                   "command accepted during a read")
  `CKS_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= FULL_COUNT,
                   "stack count above depth")
  `CKS_ASSERT_SAME(a_level_bound, clk, rst, 1'b1, level <= FULL_LEVEL,
                   "checkpoint level above depth")
  `CKS_ASSERT_NEXT(a_push_grows, clk, rst,
                   accept && (cmd.op == OP_PUSH) && (count != FULL_COUNT),
                   count == $past(count) + CW'(1),
                   "push did not grow the stack")

endmodule

### rtl/cks_cell.sv
module cks_cell #(
  parameter int STACK_DEPTH      = 16,
  parameter int CHECKPOINT_DEPTH = 4,
  parameter int INDEX            = 0,
  localparam int CW = $clog2(STACK_DEPTH + 1),
  localparam int IW = (CHECKPOINT_DEPTH > 1) ? $clog2(CHECKPOINT_DEPTH) : 1
) (
  input  logic                clk,
  input  cks_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]       count,
  input  logic [IW-1:0]       ckpt_idx,
  input  cks_pkg::word_t      push_value,
  input  cks_pkg::word_t      from_next,
  input  cks_pkg::word_t      from_bottom,
  output cks_pkg::word_t      value
);
  import cks_pkg::*;

  localparam logic [CW-1:0] MY_COUNT  = CW'(INDEX);
  localparam logic [CW-1:0] TOP_COUNT = CW'(INDEX + 1);

  // One saved copy of this entry for each checkpoint level.
  word_t column [CHECKPOINT_DEPTH];

  // The live entry: loaded by push, restored by rollback, or rotated within
  // the occupied part of the row during a read so that the bottom entry
  // comes around to the top.
  always_ff @(posedge clk) begin
    if (ctrl.push && (count == MY_COUNT)) begin
      value <= push_value;
    end else if (ctrl.rollback) begin
      value <= column[ckpt_idx];
    end else if (ctrl.rotate) begin
      value <= (count == TOP_COUNT) ? from_bottom : from_next;
    end
  end

  // Commit copies the live entry into the column slot of the new level.
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      column[ckpt_idx] <= value;
    end
  end

endmodule

### tb/cks_stack_checker.sv
module cks_stack_checker #(
  parameter int STACK_DEPTH      = 16,
  parameter int CHECKPOINT_DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  cks_cmd_if   cmd,
  cks_rsp_if   rsp,
  output int   fail_count,
  output int   results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import cks_pkg::*;

  typedef struct {
    logic [1:0] status;
    logic       has_data;
    word_t      element;
    logic       last;
  } stack_result_t;

  // Shadow copy of the stack and its saved checkpoints.
  word_t         stack_mem [STACK_DEPTH];
  int            stack_depth;
  word_t         snap_mem [CHECKPOINT_DEPTH][STACK_DEPTH];
  int            snap_depth [CHECKPOINT_DEPTH];
  int            snap_level;
  stack_result_t pending_results [$];

  // Appends one predicted result behind those already waiting.
  function automatic void stack_queue_result(stack_result_t res);
    pending_results = {pending_results, res};
  endfunction

  // Applies one accepted operation to the shadow stack and queues the
  // results it should produce, in order.
  function automatic void stack_apply_op(logic [2:0] op, word_t value);
    stack_result_t res;
    res.status   = ST_OK;
    res.has_data = 1'b0;
    res.element  = '0;
    res.last     = 1'b1;
    case (op)
      OP_PUSH: begin
        if (stack_depth >= STACK_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          stack_mem[stack_depth] = value;
          stack_depth++;
        end
      end
      OP_POP: begin
        if (stack_depth == 0) res.status = ST_EMPTY;
        else stack_depth--;
      end
      OP_READ: begin
        if (stack_depth == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // One result per element, bottom first, last marked on the top.
          for (int i = 0; i < stack_depth; i++) begin
            res.has_data = 1'b1;
            res.element  = stack_mem[i];
            res.last     = (i == stack_depth - 1);
            stack_queue_result(res);
          end
          return;
        end
      end
      OP_COMMIT: begin
        if (snap_level >= CHECKPOINT_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          snap_mem[snap_level]   = stack_mem;
          snap_depth[snap_level] = stack_depth;
          snap_level++;
        end
      end
      OP_ROLLBACK: begin
        if (snap_level == 0) begin
          res.status = ST_EMPTY;
        end else begin
          snap_level--;
          stack_depth = snap_depth[snap_level];
          stack_mem   = snap_mem[snap_level];
        end
      end
      OP_CLEAR: begin
        stack_depth = 0;
        snap_level  = 0;
      end
      default: return;  // Unused codes change nothing and give no result.
    endcase
    stack_queue_result(res);
  endfunction

  // Compares one result transfer with the oldest pending result.
  function automatic void stack_compare_result();
    stack_result_t want;
    if (pending_results.size() == 0) begin
      $error("result with nothing pending: status %0d has_data %0d element %0d last %0d",
             rsp.status, rsp.has_data, rsp.element, rsp.last);
      fail_count++;
      return;
    end
    want = pending_results.pop_front();
    if (rsp.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, rsp.status);
      fail_count++;
    end
    if (rsp.has_data !== want.has_data) begin
      $error("has_data: expected %0d, got %0d", want.has_data, rsp.has_data);
      fail_count++;
    end
    if (rsp.element !== want.element) begin
      $error("element: expected %0d, got %0d", want.element, rsp.element);
      fail_count++;
    end
    if (rsp.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, rsp.last);
      fail_count++;
    end
  endfunction

  // Results are checked before the same edge's command is predicted, since
  // a result can never come from a command accepted at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      stack_depth = 0;
      snap_level  = 0;
      fail_count  = 0;
      pending_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) stack_compare_result();
      if (cmd.valid && cmd.ready) stack_apply_op(cmd.op, cmd.push_value);
    end
    results_due <= pending_results.size();
  end

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cks_pkg::*;

  localparam int STACK_DEPTH      = 16;
  localparam int CHECKPOINT_DEPTH = 4;
  localparam int RANDOM_ITEMS     = 90;

  // Op codes the block does not define; they must be ignored.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic clk;
  logic rst;
  int   fail_count;
  int   results_due;
  int   ops_sent;
  int   send_calm;
  int   stall_left;
  int   ready_calm;

  cks_cmd_if cmd_ch ();
  cks_rsp_if rsp_ch ();

  checkpointed_stack_top #(
    .STACK_DEPTH      (STACK_DEPTH),
    .CHECKPOINT_DEPTH (CHECKPOINT_DEPTH)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  cks_stack_checker #(
    .STACK_DEPTH      (STACK_DEPTH),
    .CHECKPOINT_DEPTH (CHECKPOINT_DEPTH)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Idle lengths: mostly short, now and then long.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) return $urandom_range(1, 2);
    if (pick < 19) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  // Gap before the next command; calm stretches send back to back.
  function int sender_gap();
    int pick;
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    pick = $urandom_range(0, 19);
    if (pick == 0) send_calm = $urandom_range(15, 40);
    if (pick < 10) return 0;
    return idle_len();
  endfunction

  // Values biased toward the extremes of a signed word.
  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      3: return -32'sd1;
      default: return word_t'($urandom);
    endcase
  endfunction

  // Response back-pressure: random stalls with occasional calm stretches.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if (ready_calm > 0) begin
      ready_calm--;
      rsp_ch.ready <= 1'b1;
    end else begin
      case ($urandom_range(0, 9))
        0:       ready_calm = $urandom_range(20, 60);
        1, 2, 3: stall_left = idle_len();
        default: ;
      endcase
      rsp_ch.ready <= (stall_left == 0);
    end
  end

  // Presents one command after a random gap and waits for its transfer.
  task automatic send_op(input logic [2:0] op, input word_t value);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      cmd_ch.valid      <= 1'b0;
      cmd_ch.op         <= 3'($urandom_range(0, 7));
      cmd_ch.push_value <= word_t'($urandom);
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.op         <= op;
    cmd_ch.push_value <= value;
    do @(posedge clk); while (!cmd_ch.ready);
    if (op <= OP_CLEAR) ops_sent++;
  endtask

  // Holds off the sender until every pending result has been taken.
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  // Pushes up to or past the full mark, reads the whole stack back, then pops up to three entries.
  task automatic fill_stack();
    if ($urandom_range(0, 1)) send_op(OP_CLEAR, rand_word());
    repeat ($urandom_range(STACK_DEPTH, STACK_DEPTH + 2)) send_op(OP_PUSH, rand_word());
    send_op(OP_READ, rand_word());
    repeat ($urandom_range(0, 3)) send_op(OP_POP, rand_word());
  endtask

  // Nests checkpoints up to or past the history limit, then unwinds them all.
  task automatic walk_checkpoints();
    repeat ($urandom_range(CHECKPOINT_DEPTH, CHECKPOINT_DEPTH + 1)) begin
      repeat ($urandom_range(0, 3)) send_op(OP_PUSH, rand_word());
      if ($urandom_range(0, 3) == 0) send_op(OP_POP, rand_word());
      send_op(OP_COMMIT, rand_word());
    end
    send_op(OP_READ, rand_word());
    repeat ($urandom_range(CHECKPOINT_DEPTH, CHECKPOINT_DEPTH + 1)) begin
      send_op(OP_ROLLBACK, rand_word());
      if ($urandom_range(0, 1)) send_op(OP_READ, rand_word());
    end
  endtask

  // Weighted random operations, push heavy so the stack keeps content.
  task automatic mixed_ops(input int count);
    int pick;
    logic [2:0] op;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 36) op = OP_PUSH;
      else if (pick < 51) op = OP_POP;
      else if (pick < 66) op = OP_READ;
      else if (pick < 78) op = OP_COMMIT;
      else if (pick < 90) op = OP_ROLLBACK;
      else if (pick < 94) op = OP_CLEAR;
      else if (pick < 97) op = OP_SPARE_LO;
      else op = OP_SPARE_HI;
      send_op(op, rand_word());
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int start_count;
    rst               <= 1'b1;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.op         <= OP_PUSH;
    cmd_ch.push_value <= '0;
    ops_sent   = 0;
    send_calm  = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty cases, value extremes, history limit, ignored codes.
    send_op(OP_POP, rand_word());
    send_op(OP_READ, rand_word());
    send_op(OP_ROLLBACK, rand_word());
    send_op(OP_PUSH, 32'sh8000_0000);
    send_op(OP_PUSH, 32'sh7FFF_FFFF);
    send_op(OP_PUSH, '0);
    send_op(OP_PUSH, -32'sd1);
    send_op(OP_READ, '0);
    repeat (CHECKPOINT_DEPTH) send_op(OP_COMMIT, rand_word());
    send_op(OP_COMMIT, rand_word());
    send_op(OP_POP, rand_word());
    send_op(OP_READ, rand_word());
    send_op(OP_ROLLBACK, rand_word());
    send_op(OP_READ, rand_word());
    repeat (CHECKPOINT_DEPTH - 1) send_op(OP_ROLLBACK, rand_word());
    send_op(OP_ROLLBACK, rand_word());
    send_op(OP_SPARE_LO, rand_word());
    send_op(OP_SPARE_HI, rand_word());
    send_op(OP_CLEAR, rand_word());
    send_op(OP_READ, rand_word());
    drain();

    // Random: a full stack first, then a mix of sequences and noise.
    start_count = ops_sent;
    fill_stack();
    drain();
    while (ops_sent - start_count < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       fill_stack();
        1:       walk_checkpoints();
        default: mixed_ops($urandom_range(6, 14));
      endcase
      if ($urandom_range(0, 5) == 0) drain();
    end

    // Let the last results arrive, then allow for any stray output.
    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog in case a transfer never completes.
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
